>>> sv/basis_coefficients_cramer3_assert.svh
// Assertion macros for the basis coefficient solver.
`ifndef BASIS_COEFFICIENTS_CRAMER3_ASSERT_SVH
`define BASIS_COEFFICIENTS_CRAMER3_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// Fixed widths and constants shared by the basis coefficient solver.
// ----------------------------------------------------------------------------
package bcc_pkg;
	// Coefficient width (Q16.16 by default)
	localparam int COEF_W  = 32;
	// Quotient bits resolved by the divider: one guard bit above the coefficient
	localparam int QB      = COEF_W + 1;
	// Threshold register width
	localparam int CFG_W   = 48;
	// Result bus: three coefficients, solved, saturated, padded to bytes
	localparam int OUT_FW  = 3 * COEF_W + 2;
	localparam int OUT_TDW = ((OUT_FW + 7) / 8) * 8;
endpackage

>>> sv/basis_coefficients_cramer3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basis_coefficients_cramer3
// Expresses a target vector in a 3D basis by Cramer's rule, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream s_*: tdata holds target x,y,z then basis i,j,k (x,y,z each),
//    COORD_WIDTH bits per field, signed, lowest field in the lowest bits.
//  - Output stream m_*: one result per input: coef_i, coef_j, coef_k (Q16.16),
//    solved, saturated.
//  - cfg_we/cfg_wdata load the 48-bit determinant threshold; write while idle.
//  - The pipeline has 3 determinant stages, one divider setup stage,
//    33 divider stages (one quotient bit each, three dividers side by side),
//    one clip stage and the output register.
//  - Throughput is one item per cycle unless a result waits on m_tready; the
//    33-step divider pipeline sets the latency, not the rate.
//  - Reset clears all valid bits and sets the threshold to zero.
//  - When m_tready is low with a result waiting, the whole pipeline holds
//    and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module basis_coefficients_cramer3 #(
	parameter int COORD_WIDTH    = 16,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bcc_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// target_x, target_y, target_z, basis_i_x..z, basis_j_x..z, basis_k_x..z
	input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// coef_i, coef_j, coef_k, solved, saturated
	output logic [bcc_pkg::OUT_TDW-1:0]   m_tdata
);
	import bcc_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int DW   = 3 * W + 3;
	localparam int DLAT = QB + 2;
	localparam int LAT  = 3 + DLAT + 1;

	logic [CFG_W-1:0]       thr_q;
	logic [LAT-1:0]         vld_q;
	logic [DLAT-1:0]        sol_q;
	logic                   en;
	logic signed [DW-1:0]   d_s3, da_s3, db_s3, dc_s3;
	logic [DW-1:0]          dmag;
	logic                   solved;
	logic [COEF_W-1:0]      ci, cj, ck;
	logic                   si, sj, sk;
	logic [COEF_W-1:0]      coef_i_s, coef_j_s, coef_k_s;
	logic                   solved_s, sat_s;

	// Advance unless the output holds a result not yet taken
	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	bcc_det #(.W(W)) u_det (
		.clk    (clk),
		.en     (en),
		.coords (s_tdata[12*W-1:0]),
		.d_s3   (d_s3),
		.da_s3  (da_s3),
		.db_s3  (db_s3),
		.dc_s3  (dc_s3)
	);

	// Compare the determinant magnitude with the threshold
	always_comb begin
		dmag   = d_s3[DW-1] ? DW'(-d_s3) : DW'(d_s3);
		solved = (DW + CFG_W)'(dmag) > (DW + CFG_W)'(thr_q);
	end

	// Carry the solved flag alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			sol_q <= {sol_q[DLAT-2:0], solved};
		end
	end

	bcc_div #(.DW(DW), .FRAC(COEF_FRAC_BITS)) u_div_i (
		.clk(clk), .en(en), .num(da_s3), .den(d_s3), .coef_s(ci), .sat_s(si)
	);
	bcc_div #(.DW(DW), .FRAC(COEF_FRAC_BITS)) u_div_j (
		.clk(clk), .en(en), .num(db_s3), .den(d_s3), .coef_s(cj), .sat_s(sj)
	);
	bcc_div #(.DW(DW), .FRAC(COEF_FRAC_BITS)) u_div_k (
		.clk(clk), .en(en), .num(dc_s3), .den(d_s3), .coef_s(ck), .sat_s(sk)
	);

	// Output register: zero the result when there is no solution
	always_ff @(posedge clk) begin
		if (en) begin
			solved_s <= sol_q[DLAT-1];
			if (sol_q[DLAT-1]) begin
				coef_i_s <= ci;
				coef_j_s <= cj;
				coef_k_s <= ck;
				sat_s    <= si || sj || sk;
			end else begin
				coef_i_s <= '0;
				coef_j_s <= '0;
				coef_k_s <= '0;
				sat_s    <= 1'b0;
			end
		end
	end

	assign m_tdata = OUT_TDW'({sat_s, solved_s, coef_k_s, coef_j_s, coef_i_s});
endmodule

>>> sv/bcc_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_det
// Three-stage determinant unit: basis determinant and three Cramer numerators.
// ----------------------------------------------------------------------------
module bcc_det #(
	parameter int W = 16
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [12*W-1:0]         coords,
	output logic signed [3*W+2:0]   d_s3,
	output logic signed [3*W+2:0]   da_s3,
	output logic signed [3*W+2:0]   db_s3,
	output logic signed [3*W+2:0]   dc_s3
);
	localparam int PW = 2 * W;
	localparam int CW = 2 * W + 1;
	localparam int QW = 3 * W + 1;
	localparam int DW = 3 * W + 3;

	logic signed [W-1:0]  c [12];
	logic signed [W-1:0]  ca [3][3];
	logic signed [W-1:0]  cb [3][3];
	logic signed [PW-1:0] pa_s1 [3][3];
	logic signed [PW-1:0] pb_s1 [3][3];
	logic signed [W-1:0]  iv_s1 [3];
	logic signed [W-1:0]  tv_s1 [3];
	logic signed [CW-1:0] cr [3][3];
	logic signed [QW-1:0] pr_s2 [4][3];

	// Unpack the coordinates: t, i, j, k
	always_comb begin
		for (int n = 0; n < 12; n++) begin
			c[n] = coords[n*W +: W];
		end
		// Cross operands: j x k, t x k, j x t
		for (int n = 0; n < 3; n++) begin
			ca[0][n] = c[6+n];
			cb[0][n] = c[9+n];
			ca[1][n] = c[n];
			cb[1][n] = c[9+n];
			ca[2][n] = c[6+n];
			cb[2][n] = c[n];
		end
	end

	// Stage 1: cross product terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 3; m++) begin
				for (int n = 0; n < 3; n++) begin
					pa_s1[m][n] <= PW'(ca[m][(n+1)%3]) * PW'(cb[m][(n+2)%3]);
					pb_s1[m][n] <= PW'(ca[m][(n+2)%3]) * PW'(cb[m][(n+1)%3]);
				end
			end
			for (int n = 0; n < 3; n++) begin
				iv_s1[n] <= c[3+n];
				tv_s1[n] <= c[n];
			end
		end
	end

	// Form the crosses
	always_comb begin
		for (int m = 0; m < 3; m++) begin
			for (int n = 0; n < 3; n++) begin
				cr[m][n] = CW'(pa_s1[m][n]) - CW'(pb_s1[m][n]);
			end
		end
	end

	// Stage 2: dot product terms i.(jxk), t.(jxk), i.(txk), i.(jxt)
	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 3; n++) begin
				pr_s2[0][n] <= QW'(iv_s1[n]) * QW'(cr[0][n]);
				pr_s2[1][n] <= QW'(tv_s1[n]) * QW'(cr[0][n]);
				pr_s2[2][n] <= QW'(iv_s1[n]) * QW'(cr[1][n]);
				pr_s2[3][n] <= QW'(iv_s1[n]) * QW'(cr[2][n]);
			end
		end
	end

	// Stage 3: sum the terms
	always_ff @(posedge clk) begin
		if (en) begin
			d_s3  <= DW'(pr_s2[0][0]) + DW'(pr_s2[0][1]) + DW'(pr_s2[0][2]);
			da_s3 <= DW'(pr_s2[1][0]) + DW'(pr_s2[1][1]) + DW'(pr_s2[1][2]);
			db_s3 <= DW'(pr_s2[2][0]) + DW'(pr_s2[2][1]) + DW'(pr_s2[2][2]);
			dc_s3 <= DW'(pr_s2[3][0]) + DW'(pr_s2[3][1]) + DW'(pr_s2[3][2]);
		end
	end
endmodule

>>> sv/bcc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_div
// Pipelined restoring divider: one quotient bit per stage, saturating output.
// ----------------------------------------------------------------------------
module bcc_div #(
	parameter int DW   = 51,
	parameter int FRAC = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [DW-1:0]         num,
	input  logic signed [DW-1:0]         den,
	output logic [bcc_pkg::COEF_W-1:0]   coef_s,
	output logic                         sat_s
);
	import bcc_pkg::*;

	localparam int NW = DW + FRAC;
	localparam int RW = DW + 1;

	logic [DW-1:0] nmag;
	logic [DW-1:0] dmag;
	logic [NW-1:0] nfull;
	logic [RW-1:0] rem_s [QB+1];
	logic [QB-1:0] low_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic          neg_s [QB+1];
	logic          ovf_s [QB+1];
	logic          pos_clip;
	logic          neg_clip;
	logic [QB-1:0] qv;

	// Magnitudes and scaled numerator
	always_comb begin
		nmag  = num[DW-1] ? DW'(-num) : DW'(num);
		dmag  = den[DW-1] ? DW'(-den) : DW'(den);
		nfull = {nmag, {FRAC{1'b0}}};
	end

	// Stage 0: quotient overflow check and remainder seed
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(nfull[NW-1:QB]);
			low_s[0] <= nfull[QB-1:0];
			quo_s[0] <= '0;
			den_s[0] <= dmag;
			neg_s[0] <= num[DW-1] ^ den[DW-1];
			ovf_s[0] <= NW'(nfull[NW-1:QB]) >= NW'(dmag);
		end
	end

	// One restoring step per stage
	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [RW-1:0] trial;
		logic          fit;
		always_comb begin
			trial = {rem_s[k][RW-2:0], low_s[k][QB-1]};
			fit   = trial >= RW'(den_s[k]);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= fit ? trial - RW'(den_s[k]) : trial;
				low_s[k+1] <= {low_s[k][QB-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][QB-2:0], fit};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// Clip to the coefficient range
	always_comb begin
		qv       = quo_s[QB];
		pos_clip = !neg_s[QB] && (ovf_s[QB] || qv > QB'({1'b0, {(COEF_W-1){1'b1}}}));
		neg_clip = neg_s[QB] && (ovf_s[QB] || qv > QB'({1'b1, {(COEF_W-1){1'b0}}}));
	end

	// Final stage: apply sign or saturate
	always_ff @(posedge clk) begin
		if (en) begin
			sat_s <= pos_clip || neg_clip;
			if (pos_clip) begin
				coef_s <= {1'b0, {(COEF_W-1){1'b1}}};
			end else if (neg_clip) begin
				coef_s <= {1'b1, {(COEF_W-1){1'b0}}};
			end else if (neg_s[QB]) begin
				coef_s <= -qv[COEF_W-1:0];
			end else begin
				coef_s <= qv[COEF_W-1:0];
			end
		end
	end
endmodule

>>> sv/bcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks on the result stream of the basis coefficient solver.
// ----------------------------------------------------------------------------
`include "basis_coefficients_cramer3_assert.svh"

module bcc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [bcc_pkg::OUT_TDW-1:0] m_tdata
);
	import bcc_pkg::*;

	logic solved;
	logic sat;

	assign solved = m_tdata[3*COEF_W];
	assign sat    = m_tdata[3*COEF_W+1];

	// No solution means zero coefficients and no clipping
	`BCC_ASSERT_NOW(a_unsolved_zero, clk, arst_n, m_tvalid && !solved, m_tdata[3*COEF_W+1:0] == '0, "unsolved result is not zero")
	// Clipping only happens on a solved result
	`BCC_ASSERT_NOW(a_sat_solved, clk, arst_n, m_tvalid && sat, solved, "saturated without solution")
	// A stalled result stays offered
	`BCC_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result dropped or changed")
endmodule

bind basis_coefficients_cramer3 bcc_checker u_bcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
